// File: rtl/rqr_pkg.sv
// ----------------------------------------------------------------------------
// rqr_pkg
// Shared types, codes and defaults for the RED queue router port.
// ----------------------------------------------------------------------------
package rqr_pkg;

  localparam int QUEUE_DEPTH_DEF   = 64;
  localparam int ROUTE_ENTRIES_DEF = 16;
  localparam int MAX_LINKS_DEF     = 8;

  localparam logic [1:0] OP_ARRIVE = 2'd0;
  localparam logic [1:0] OP_SEND   = 2'd1;
  localparam logic [1:0] OP_ROUTE  = 2'd2;

  localparam logic [2:0] OUT_ENQUEUED = 3'd0;
  localparam logic [2:0] OUT_DROPPED  = 3'd1;
  localparam logic [2:0] OUT_FORWARD  = 3'd2;
  localparam logic [2:0] OUT_EMPTY    = 3'd3;
  localparam logic [2:0] OUT_NO_ROUTE = 3'd4;
  localparam logic [2:0] OUT_DISCARD  = 3'd5;
  localparam logic [2:0] OUT_ADDED    = 3'd6;
  localparam logic [2:0] OUT_REJECTED = 3'd7;

  localparam logic [2:0] CFG_MIN_LEVEL   = 3'd0;
  localparam logic [2:0] CFG_MAX_LEVEL   = 3'd1;
  localparam logic [2:0] CFG_DROP_SLOPE  = 3'd2;
  localparam logic [2:0] CFG_DROP_OFFSET = 3'd3;
  localparam logic [2:0] CFG_LINK_COUNT  = 3'd4;

  localparam logic [6:0]  MIN_LEVEL_RST   = 7'd2;
  localparam logic [6:0]  MAX_LEVEL_RST   = 7'd6;
  localparam logic [15:0] DROP_SLOPE_RST  = 16'd19661;
  localparam logic [15:0] DROP_OFFSET_RST = 16'd26214;
  localparam logic [3:0]  LINK_COUNT_RST  = 4'd0;

  typedef struct packed {
    logic [1:0]  op;
    logic [15:0] pkt_id;
    logic [7:0]  pkt_source;
    logic [7:0]  pkt_dest;
    logic [15:0] random_value;
    logic [7:0]  table_dest_id;
    logic [2:0]  table_link;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  outcome;
    logic [2:0]  out_link;
    logic [15:0] out_id;
    logic [7:0]  out_source;
    logic [7:0]  out_dest;
    logic [6:0]  queue_level;
    logic        congestion;
  } out_item_t;

  typedef struct packed {
    logic [15:0] id;
    logic [7:0]  source;
    logic [7:0]  dest;
  } pkt_t;

  typedef struct packed {
    logic [7:0] dest;
    logic [2:0] link;
  } route_t;

  typedef struct packed {
    logic [6:0]  min_level;
    logic [6:0]  max_level;
    logic [15:0] drop_slope;
    logic [15:0] drop_offset;
  } red_cfg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ARRIVE,
    ST_POP,
    ST_SCAN
  } state_t;

endpackage

// File: rtl/rqr_ram.sv
// ----------------------------------------------------------------------------
// rqr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rqr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/rqr_red.sv
// ----------------------------------------------------------------------------
// rqr_red
// RED admission test: registers level compares and the slope product at
// accept, resolves the drop decision in the following cycle.
// ----------------------------------------------------------------------------
module rqr_red import rqr_pkg::*; #(
  parameter int CNT_W = 7
) (
  input  logic             clk,
  input  logic             load,
  input  red_cfg_t         cfg,
  input  logic [CNT_W-1:0] count,
  input  logic [15:0]      rnd,
  output logic             drop
);

  localparam int LW = (CNT_W > 7) ? CNT_W : 7;
  localparam int PW = 16 + CNT_W;

  logic          lt_min_r;
  logic          ge_max_r;
  logic [16:0]   sum_r;
  logic [PW-1:0] prod_r;

  always_ff @(posedge clk) begin
    if (load) begin
      lt_min_r <= LW'(count) < LW'(cfg.min_level);
      ge_max_r <= LW'(count) >= LW'(cfg.max_level);
      sum_r    <= 17'(rnd) + 17'(cfg.drop_offset);
      prod_r   <= PW'(cfg.drop_slope) * PW'(count);
    end
  end

  assign drop = !lt_min_r && (ge_max_r || (PW'(sum_r) < prod_r));

endmodule

// File: rtl/red_queue_router_port_core.sv
// ----------------------------------------------------------------------------
// red_queue_router_port_core
// Router output port: packet FIFO under RED admission plus a first-match
// destination-to-link table, both held in synchronous RAMs.
// ----------------------------------------------------------------------------
// Flow: an arrival passes ST_ARRIVE; a send slot passes ST_POP, then ST_SCAN once
//   per table entry scanned (bounded by the entry count) when links and entries exist;
//   table add, empty send and op 3 resolve in ST_IDLE. One item at a time: busy is high outside ST_IDLE.
// Results appear on out_valid for one cycle; the receiver cannot stall.
// Reset (rst_n low, synchronous) empties queue and table and restores the
//   default registers; RAM contents are left as they are.
module red_queue_router_port_core import rqr_pkg::*; #(
  parameter int QUEUE_DEPTH   = QUEUE_DEPTH_DEF,
  parameter int ROUTE_ENTRIES = ROUTE_ENTRIES_DEF,
  parameter int MAX_LINKS     = MAX_LINKS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  in_item_t    in_item,
  output logic        out_valid,
  output out_item_t   out_item,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int QAW = $clog2(QUEUE_DEPTH);
  localparam int CW  = $clog2(QUEUE_DEPTH + 1);
  localparam int RAW = (ROUTE_ENTRIES > 1) ? $clog2(ROUTE_ENTRIES) : 1;
  localparam int RCW = $clog2(ROUTE_ENTRIES + 1);
  localparam int LKW = ($clog2(MAX_LINKS + 1) > 4) ? $clog2(MAX_LINKS + 1) : 4;

  red_cfg_t   red_cfg_r;
  logic [3:0] link_count_r;

  state_t         state_r, state_nxt;
  logic [QAW-1:0] head_r, head_nxt;
  logic [QAW-1:0] tail_r, tail_nxt;
  logic [CW-1:0]  count_r, count_nxt;
  logic [RCW-1:0] rcount_r, rcount_nxt;
  logic [RAW-1:0] idx_r, idx_nxt;
  in_item_t       item_r, item_nxt;
  pkt_t           pkt_r, pkt_nxt;
  logic           out_valid_r, out_valid_nxt;
  out_item_t      out_item_r, out_item_nxt;

  logic           red_load;
  logic           red_drop;
  logic           pq_we;
  pkt_t           pq_wdata;
  pkt_t           pq_rdata;
  logic           rt_we;
  route_t         rt_wdata;
  logic [RAW-1:0] rt_raddr;
  route_t         rt_rdata;
  logic [LKW-1:0] links_lim;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      red_cfg_r.min_level   <= MIN_LEVEL_RST;
      red_cfg_r.max_level   <= MAX_LEVEL_RST;
      red_cfg_r.drop_slope  <= DROP_SLOPE_RST;
      red_cfg_r.drop_offset <= DROP_OFFSET_RST;
      link_count_r          <= LINK_COUNT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MIN_LEVEL:   red_cfg_r.min_level   <= cfg_data[6:0];
        CFG_MAX_LEVEL:   red_cfg_r.max_level   <= cfg_data[6:0];
        CFG_DROP_SLOPE:  red_cfg_r.drop_slope  <= cfg_data;
        CFG_DROP_OFFSET: red_cfg_r.drop_offset <= cfg_data;
        CFG_LINK_COUNT:  link_count_r          <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  assign links_lim = (LKW'(link_count_r) > LKW'(MAX_LINKS)) ? LKW'(MAX_LINKS)
                                                            : LKW'(link_count_r);

  rqr_red #(
    .CNT_W (CW)
  ) u_red (
    .clk   (clk),
    .load  (red_load),
    .cfg   (red_cfg_r),
    .count (count_r),
    .rnd   (in_item.random_value),
    .drop  (red_drop)
  );

  rqr_ram #(
    .WIDTH ($bits(pkt_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_pkt_ram (
    .clk   (clk),
    .we    (pq_we),
    .waddr (tail_r),
    .wdata (pq_wdata),
    .raddr (head_r),
    .rdata (pq_rdata)
  );

  rqr_ram #(
    .WIDTH ($bits(route_t)),
    .DEPTH (ROUTE_ENTRIES)
  ) u_route_ram (
    .clk   (clk),
    .we    (rt_we),
    .waddr (RAW'(rcount_r)),
    .wdata (rt_wdata),
    .raddr (rt_raddr),
    .rdata (rt_rdata)
  );

  assign pq_wdata.id     = item_r.pkt_id;
  assign pq_wdata.source = item_r.pkt_source;
  assign pq_wdata.dest   = item_r.pkt_dest;
  assign rt_wdata.dest   = in_item.table_dest_id;
  assign rt_wdata.link   = in_item.table_link;

  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    count_nxt     = count_r;
    rcount_nxt    = rcount_r;
    idx_nxt       = idx_r;
    item_nxt      = item_r;
    pkt_nxt       = pkt_r;
    red_load      = 1'b0;
    pq_we         = 1'b0;
    rt_we         = 1'b0;
    rt_raddr      = idx_r;
    out_valid_nxt = 1'b0;
    out_item_nxt  = '0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          item_nxt = in_item;
          case (in_item.op)
            OP_ARRIVE: begin
              red_load  = 1'b1;
              state_nxt = ST_ARRIVE;
            end
            OP_SEND: begin
              if (count_r == '0) begin
                out_valid_nxt        = 1'b1;
                out_item_nxt.outcome = OUT_EMPTY;
              end else begin
                head_nxt  = (head_r == QAW'(QUEUE_DEPTH - 1)) ? '0 : head_r + 1'b1;
                count_nxt = count_r - 1'b1;
                state_nxt = ST_POP;
              end
            end
            OP_ROUTE: begin
              out_valid_nxt = 1'b1;
              if ((LKW'(in_item.table_link) < links_lim) &&
                  (rcount_r < RCW'(ROUTE_ENTRIES))) begin
                rt_we                = 1'b1;
                rcount_nxt           = rcount_r + 1'b1;
                out_item_nxt.outcome = OUT_ADDED;
              end else begin
                out_item_nxt.outcome = OUT_REJECTED;
              end
            end
            default: begin
              out_valid_nxt        = 1'b1;
              out_item_nxt.outcome = OUT_REJECTED;
            end
          endcase
        end
      end
      ST_ARRIVE: begin
        out_valid_nxt = 1'b1;
        state_nxt     = ST_IDLE;
        if (red_drop || (count_r == CW'(QUEUE_DEPTH))) begin
          out_item_nxt.outcome    = OUT_DROPPED;
          out_item_nxt.congestion = 1'b1;
        end else begin
          pq_we                = 1'b1;
          tail_nxt             = (tail_r == QAW'(QUEUE_DEPTH - 1)) ? '0 : tail_r + 1'b1;
          count_nxt            = count_r + 1'b1;
          out_item_nxt.outcome = OUT_ENQUEUED;
        end
      end
      ST_POP: begin
        pkt_nxt  = pq_rdata;
        rt_raddr = '0;
        idx_nxt  = '0;
        if (link_count_r == '0) begin
          out_valid_nxt           = 1'b1;
          out_item_nxt.outcome    = OUT_DISCARD;
          out_item_nxt.out_id     = pq_rdata.id;
          out_item_nxt.out_source = pq_rdata.source;
          out_item_nxt.out_dest   = pq_rdata.dest;
          state_nxt               = ST_IDLE;
        end else if (rcount_r == '0) begin
          out_valid_nxt           = 1'b1;
          out_item_nxt.outcome    = OUT_NO_ROUTE;
          out_item_nxt.out_id     = pq_rdata.id;
          out_item_nxt.out_source = pq_rdata.source;
          out_item_nxt.out_dest   = pq_rdata.dest;
          state_nxt               = ST_IDLE;
        end else begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (rt_rdata.dest == pkt_r.dest) begin
          out_valid_nxt           = 1'b1;
          out_item_nxt.outcome    = OUT_FORWARD;
          out_item_nxt.out_link   = rt_rdata.link;
          out_item_nxt.out_id     = pkt_r.id;
          out_item_nxt.out_source = pkt_r.source;
          out_item_nxt.out_dest   = pkt_r.dest;
          state_nxt               = ST_IDLE;
        end else if (((RCW + 1)'(idx_r) + (RCW + 1)'(1)) >= (RCW + 1)'(rcount_r)) begin
          out_valid_nxt           = 1'b1;
          out_item_nxt.outcome    = OUT_NO_ROUTE;
          out_item_nxt.out_id     = pkt_r.id;
          out_item_nxt.out_source = pkt_r.source;
          out_item_nxt.out_dest   = pkt_r.dest;
          state_nxt               = ST_IDLE;
        end else begin
          idx_nxt  = idx_r + 1'b1;
          rt_raddr = idx_r + 1'b1;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
    out_item_nxt.queue_level = 7'(count_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      rcount_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      count_r     <= count_nxt;
      rcount_r    <= rcount_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    item_r     <= item_nxt;
    pkt_r      <= pkt_nxt;
    out_item_r <= out_item_nxt;
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

// File: bench/red_queue_router_port_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// red_queue_router_port_checker
// Watches the item, result and register ports of the router port, keeps its
// own copy of the RED queue, routing table and registers, predicts one result
// per accepted item and compares every result field against the oldest
// prediction. Reports the failure count and the number of results outstanding.
// ----------------------------------------------------------------------------
module red_queue_router_port_checker import rqr_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        busy,
  input  in_item_t    in_item,
  input  logic        out_valid,
  input  out_item_t   out_item,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output int          fail_count,
  output int          pending
);

  localparam int EXP_DEPTH = 16;

  pkt_t        queue_mem [QUEUE_DEPTH_DEF];
  logic [5:0]  head_ptr;
  logic [5:0]  tail_ptr;
  logic [6:0]  level;
  route_t      route_tab [ROUTE_ENTRIES_DEF];
  logic [4:0]  route_cnt;
  logic [6:0]  min_lvl;
  logic [6:0]  max_lvl;
  logic [15:0] slope;
  logic [15:0] offset;
  logic [3:0]  links;
  out_item_t   exp_fifo [EXP_DEPTH];
  logic [3:0]  exp_wr;
  logic [3:0]  exp_rd;
  int          exp_cnt;
  int          errs = 0;

  function automatic logic red_drops(logic [15:0] rnd);
    longint prob;
    prob = longint'(slope) * longint'(level) - longint'(offset);
    if (level < min_lvl) return 1'b0;
    if (level >= max_lvl) return 1'b1;
    return longint'(rnd) < prob;
  endfunction

  function automatic out_item_t port_step(in_item_t it);
    out_item_t  r;
    pkt_t       p;
    logic [3:0] seen;
    logic       hit;
    r    = '0;
    hit  = 1'b0;
    seen = (links > MAX_LINKS_DEF) ? 4'(MAX_LINKS_DEF) : links;
    case (it.op)
      OP_ARRIVE: begin
        if (red_drops(it.random_value) || level >= QUEUE_DEPTH_DEF) begin
          r.outcome    = OUT_DROPPED;
          r.congestion = 1'b1;
        end else begin
          queue_mem[tail_ptr] = '{it.pkt_id, it.pkt_source, it.pkt_dest};
          tail_ptr  = tail_ptr + 6'd1;
          level     = level + 7'd1;
          r.outcome = OUT_ENQUEUED;
        end
      end
      OP_SEND: begin
        if (level == 7'd0) begin
          r.outcome = OUT_EMPTY;
        end else begin
          p            = queue_mem[head_ptr];
          head_ptr     = head_ptr + 6'd1;
          level        = level - 7'd1;
          r.out_id     = p.id;
          r.out_source = p.source;
          r.out_dest   = p.dest;
          if (links == 4'd0) begin
            r.outcome = OUT_DISCARD;
          end else begin
            // first matching entry wins
            for (int i = 0; i < route_cnt; i++) begin
              if (!hit && route_tab[i].dest == p.dest) begin
                hit        = 1'b1;
                r.out_link = route_tab[i].link;
              end
            end
            r.outcome = hit ? OUT_FORWARD : OUT_NO_ROUTE;
          end
        end
      end
      OP_ROUTE: begin
        if (it.table_link < seen && route_cnt < ROUTE_ENTRIES_DEF) begin
          route_tab[route_cnt] = '{it.table_dest_id, it.table_link};
          route_cnt = route_cnt + 5'd1;
          r.outcome = OUT_ADDED;
        end else begin
          r.outcome = OUT_REJECTED;
        end
      end
      default: r.outcome = OUT_REJECTED;
    endcase
    r.queue_level = level;
    return r;
  endfunction

  task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      errs++;
    end
  endtask

  always @(posedge clk) begin : watch
    out_item_t want;
    if (!rst_n) begin
      head_ptr  = '0;
      tail_ptr  = '0;
      level     = '0;
      route_cnt = '0;
      min_lvl   = MIN_LEVEL_RST;
      max_lvl   = MAX_LEVEL_RST;
      slope     = DROP_SLOPE_RST;
      offset    = DROP_OFFSET_RST;
      links     = LINK_COUNT_RST;
      exp_wr    = '0;
      exp_rd    = '0;
      exp_cnt   = 0;
      pending <= 0;
    end else begin
      if (out_valid) begin
        if (exp_cnt == 0) begin
          $error("result with no item outstanding: outcome %0d", out_item.outcome);
          errs++;
        end else begin
          want    = exp_fifo[exp_rd];
          exp_rd  = exp_rd + 4'd1;
          exp_cnt = exp_cnt - 1;
          check_field("outcome", 16'(want.outcome), 16'(out_item.outcome));
          check_field("out_link", 16'(want.out_link), 16'(out_item.out_link));
          check_field("out_id", want.out_id, out_item.out_id);
          check_field("out_source", 16'(want.out_source), 16'(out_item.out_source));
          check_field("out_dest", 16'(want.out_dest), 16'(out_item.out_dest));
          check_field("queue_level", 16'(want.queue_level), 16'(out_item.queue_level));
          check_field("congestion", 16'(want.congestion), 16'(out_item.congestion));
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_MIN_LEVEL:   min_lvl = cfg_data[6:0];
          CFG_MAX_LEVEL:   max_lvl = cfg_data[6:0];
          CFG_DROP_SLOPE:  slope   = cfg_data;
          CFG_DROP_OFFSET: offset  = cfg_data;
          CFG_LINK_COUNT:  links   = cfg_data[3:0];
          default: ;
        endcase
      end
      if (start && !busy) begin
        exp_fifo[exp_wr] = port_step(in_item);
        exp_wr           = exp_wr + 4'd1;
        exp_cnt          = exp_cnt + 1;
      end
      pending <= exp_cnt;
    end
    fail_count <= errs;
  end

endmodule

// File: bench/red_queue_router_port_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// red_queue_router_port_core_tb
// Drives the router port with a short directed run over edge values, an empty queue,
// crossed thresholds, clamped and stale links, then random arrival, send and table
// traffic across several register settings with random gaps. The checker beside
// the block predicts and compares results.
// ----------------------------------------------------------------------------
module red_queue_router_port_core_tb;
  import rqr_pkg::*;

  localparam logic [1:0] OP_SPARE    = 2'd3;
  localparam int         CYCLE_LIMIT = 400000;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  in_item_t    in_item;
  logic        out_valid;
  out_item_t   out_item;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_data;
  int          fail_count;
  int          pending;
  int          cycle_count = 0;

  red_queue_router_port_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  red_queue_router_port_checker router_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_item    (in_item),
    .out_valid  (out_valid),
    .out_item   (out_item),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic in_item_t pack_item(logic [1:0] op, logic [15:0] id,
                                         logic [7:0] src, logic [7:0] dst,
                                         logic [15:0] rnd, logic [7:0] tdst,
                                         logic [2:0] tlink);
    in_item_t r;
    r = '{op, id, src, dst, rnd, tdst, tlink};
    return r;
  endfunction

  function automatic in_item_t random_item(int arrive_pct, int send_pct);
    in_item_t r;
    int       pick;
    pick            = $urandom_range(0, 99);
    r.pkt_id        = 16'($urandom);
    r.pkt_source    = 8'($urandom);
    r.pkt_dest      = ($urandom_range(0, 3) != 0) ? 8'($urandom_range(0, 15)) : 8'($urandom);
    r.random_value  = 16'($urandom);
    r.table_dest_id = ($urandom_range(0, 3) != 0) ? 8'($urandom_range(0, 15)) : 8'($urandom);
    r.table_link    = 3'($urandom);
    if (pick < arrive_pct) r.op = OP_ARRIVE;
    else if (pick < arrive_pct + send_pct) r.op = OP_SEND;
    else if (pick < 97) r.op = OP_ROUTE;
    else r.op = OP_SPARE;
    return r;
  endfunction

  // hold start high across back-to-back items
  task automatic issue(in_item_t it, int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic settle();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0 || busy) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_regs(logic [6:0] min_lvl, logic [6:0] max_lvl, logic [15:0] slope,
                          logic [15:0] offset, logic [3:0] links);
    settle();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_MIN_LEVEL;
    cfg_data  <= 16'(min_lvl);
    @(posedge clk);
    cfg_index <= CFG_MAX_LEVEL;
    cfg_data  <= 16'(max_lvl);
    @(posedge clk);
    cfg_index <= CFG_DROP_SLOPE;
    cfg_data  <= slope;
    @(posedge clk);
    cfg_index <= CFG_DROP_OFFSET;
    cfg_data  <= offset;
    @(posedge clk);
    cfg_index <= CFG_LINK_COUNT;
    cfg_data  <= 16'(links);
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic run_phase(int count, int arrive_pct, int send_pct);
    int gap;
    for (int i = 0; i < count; i++) begin
      gap = (i % 50 < 15) ? 0 : $urandom_range(0, 12);
      issue(random_item(arrive_pct, send_pct), gap);
    end
  endtask

  initial begin
    clk       = 1'b0;
    rst_n     = 1'b0;
    start     = 1'b0;
    in_item   = '0;
    cfg_we    = 1'b0;
    cfg_index = CFG_MIN_LEVEL;
    cfg_data  = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // default registers, no links
    issue(pack_item(OP_SEND, 16'h0, 8'h0, 8'h0, 16'h0, 8'h0, 3'd0), 0);
    issue(pack_item(OP_SPARE, 16'hFFFF, 8'hFF, 8'hFF, 16'hFFFF, 8'hFF, 3'd7), 2);
    issue(pack_item(OP_ROUTE, 16'h0, 8'h0, 8'h0, 16'h0, 8'h05, 3'd0), 0);
    issue(pack_item(OP_ARRIVE, 16'hFFFF, 8'hFF, 8'hFF, 16'h0, 8'hFF, 3'd7), 1);
    issue(pack_item(OP_ARRIVE, 16'h0, 8'h0, 8'h0, 16'hFFFF, 8'h0, 3'd0), 0);
    issue(pack_item(OP_SEND, 16'h0, 8'h0, 8'h0, 16'h0, 8'h0, 3'd0), 3);

    set_regs(7'd2, 7'd6, 16'd19661, 16'd26214, 4'd3);
    issue(pack_item(OP_ROUTE, 16'h0, 8'h0, 8'h0, 16'h0, 8'h00, 3'd2), 0);
    issue(pack_item(OP_ROUTE, 16'h0, 8'h0, 8'h0, 16'h0, 8'hFF, 3'd3), 0);
    issue(pack_item(OP_ROUTE, 16'h0, 8'h0, 8'h0, 16'h0, 8'h00, 3'd1), 1);
    issue(pack_item(OP_ARRIVE, 16'h1234, 8'h11, 8'h80, 16'h0, 8'h0, 3'd0), 0);
    issue(pack_item(OP_ARRIVE, 16'h5678, 8'h22, 8'h00, 16'h0, 8'h0, 3'd0), 0);
    issue(pack_item(OP_ARRIVE, 16'h9ABC, 8'h33, 8'h00, 16'hFFFF, 8'h0, 3'd0), 2);
    issue(pack_item(OP_SEND, 16'h0, 8'h0, 8'h0, 16'h0, 8'h0, 3'd0), 0);
    issue(pack_item(OP_SEND, 16'h0, 8'h0, 8'h0, 16'h0, 8'h0, 3'd0), 0);

    // crossed thresholds and a link count above the link limit
    set_regs(7'd64, 7'd0, 16'hFFFF, 16'hFFFF, 4'd15);
    issue(pack_item(OP_ROUTE, 16'h0, 8'h0, 8'h0, 16'h0, 8'hAA, 3'd7), 0);
    issue(pack_item(OP_ARRIVE, 16'hBEEF, 8'h44, 8'hAA, 16'h0, 8'h0, 3'd0), 0);
    issue(pack_item(OP_SEND, 16'h0, 8'h0, 8'h0, 16'h0, 8'h0, 3'd0), 1);

    // slope times level below the offset
    set_regs(7'd0, 7'd64, 16'd0, 16'hFFFF, 4'd8);
    issue(pack_item(OP_ARRIVE, 16'h0F0F, 8'h55, 8'hAA, 16'h0, 8'h0, 3'd0), 0);
    issue(pack_item(OP_ARRIVE, 16'hF0F0, 8'hAA, 8'h00, 16'h0, 8'h0, 3'd0), 0);

    set_regs(7'd0, 7'd0, 16'hFFFF, 16'd0, 4'd1);
    issue(pack_item(OP_ARRIVE, 16'h7777, 8'h66, 8'h01, 16'hFFFF, 8'h0, 3'd0), 0);
    issue(pack_item(OP_SEND, 16'h0, 8'h0, 8'h0, 16'h0, 8'h0, 3'd0), 0);
    issue(pack_item(OP_SEND, 16'h0, 8'h0, 8'h0, 16'h0, 8'h0, 3'd0), 0);

    set_regs(7'd2, 7'd6, 16'd19661, 16'd26214, 4'd8);
    run_phase(100, 45, 40);
    set_regs(7'd0, 7'd64, 16'd0, 16'd0, 4'd8);
    run_phase(150, 80, 15);
    set_regs(7'd10, 7'd40, 16'd2000, 16'd20000, 4'd4);
    run_phase(100, 40, 50);
    set_regs(7'd64, 7'd0, 16'hFFFF, 16'hFFFF, 4'd15);
    run_phase(100, 55, 40);
    set_regs(7'd0, 7'd0, 16'hFFFF, 16'd0, 4'd1);
    run_phase(80, 30, 65);
    set_regs(7'd3, 7'd20, 16'hFFFF, 16'd0, 4'd2);
    run_phase(120, 50, 45);

    settle();
    repeat (20) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
